// ===== hdl/fat_text_to_short_name_unit_assert.svh =====
// Assertion macros shared by the checker of the short name unit.
// No dependencies; included by bare file name where assertions are written.
`ifndef FAT_TEXT_TO_SHORT_NAME_UNIT_ASSERT_SVH
`define FAT_TEXT_TO_SHORT_NAME_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define FTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/fts_pkg.sv =====
// Package for the short name unit: byte constants, item and result types.
// No dependencies; used by every module of the unit.
package fts_pkg;

    localparam int unsigned NameLen = 8;
    localparam int unsigned ExtLen  = 3;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] DOT_CODE     = 8'h2E;
    localparam logic [7:0] DELETED_MARK = 8'hE5;
    localparam logic [7:0] DELETED_ESC  = 8'h05;
    localparam logic [7:0] LOWER_A      = 8'h61;
    localparam logic [7:0] LOWER_Z      = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One classified input character as held in the input register.
    typedef struct packed {
        logic       last;
        logic       skip;
        logic       is_dot;
        logic       is_space;
        logic [7:0] code;
    } char_info_t;

    // One finished short name.
    typedef struct packed {
        logic        status;
        logic [23:0] ext_bytes;
        logic [63:0] name_bytes;
    } result_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== hdl/fts_in_stage.sv =====
// Input register of the short name unit: upper-cases and classifies a byte.
// Depends on fts_pkg.
module fts_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_ch,
    input  logic               in_last,
    input  logic               go,
    output logic               st_valid,
    output fts_pkg::char_info_t st_info
);
    import fts_pkg::*;

    logic       st_valid_reg;
    logic       st_valid_next;
    char_info_t st_info_reg;
    char_info_t in_info;
    logic       take;

    always_comb
    begin
        in_info.code     = upcase(in_ch);
        in_info.last     = in_last;
        in_info.skip     = (in_ch == 8'h00);
        in_info.is_dot   = (in_info.code == DOT_CODE);
        in_info.is_space = (in_info.code == SPACE_CODE);
    end

    // The register can take a new byte when empty or when its byte moves on.
    assign in_ready      = !st_valid_reg || go;
    assign take          = in_valid && in_ready;
    assign st_valid_next = take ? 1'b1 : (go ? 1'b0 : st_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            st_info_reg <= in_info;
        end
    end

    assign st_valid = st_valid_reg;
    assign st_info  = st_info_reg;

endmodule

// ===== hdl/fts_assemble.sv =====
// Name assembly of the short name unit: prefix and suffix stores, counters,
// and the padded result built on a terminator. Depends on fts_pkg.
module fts_assemble (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                st_valid,
    input  fts_pkg::char_info_t st_info,
    input  logic                out_free,
    output logic                go,
    output logic                res_load,
    output fts_pkg::result_t    res
);
    import fts_pkg::*;

    logic [7:0] prefix_store_reg [NameLen];
    logic [7:0] prefix_store_next[NameLen];
    logic [7:0] suffix_store_reg [ExtLen];
    logic [7:0] suffix_store_next[ExtLen];
    logic [3:0] prefix_count_reg, prefix_count_next;
    logic [3:0] cut_length_reg,   cut_length_next;
    logic [1:0] suffix_count_reg, suffix_count_next;
    logic       dot_seen_reg,     dot_seen_next;
    logic       started_reg,      started_next;

    // A terminator waits until the output register can take the result.
    assign go       = st_valid && (!st_info.last || out_free);
    assign res_load = go && st_info.last;

    always_comb
    begin
        prefix_store_next = prefix_store_reg;
        suffix_store_next = suffix_store_reg;
        prefix_count_next = prefix_count_reg;
        cut_length_next   = cut_length_reg;
        suffix_count_next = suffix_count_reg;
        dot_seen_next     = dot_seen_reg;
        started_next      = started_reg;
        if (go)
        begin
            if (st_info.last)
            begin
                prefix_count_next = 4'd0;
                cut_length_next   = 4'd0;
                suffix_count_next = 2'd0;
                dot_seen_next     = 1'b0;
                started_next      = 1'b0;
            end
            else if (!st_info.skip)
            begin
                // A dot is a separator unless it is the first byte of the name.
                if (st_info.is_dot && started_reg)
                begin
                    dot_seen_next     = 1'b1;
                    cut_length_next   = prefix_count_reg;
                    suffix_count_next = 2'd0;
                end
                else if (!st_info.is_space && dot_seen_reg
                         && suffix_count_reg != 2'(ExtLen))
                begin
                    suffix_store_next[suffix_count_reg] = st_info.code;
                    suffix_count_next = suffix_count_reg + 2'd1;
                end
                // The separator dot itself lands in the prefix too.
                if (!st_info.is_space && prefix_count_reg != 4'(NameLen))
                begin
                    prefix_store_next[prefix_count_reg[2:0]] = st_info.code;
                    prefix_count_next = prefix_count_reg + 4'd1;
                end
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_count_reg <= 4'd0;
            cut_length_reg   <= 4'd0;
            suffix_count_reg <= 2'd0;
            dot_seen_reg     <= 1'b0;
            started_reg      <= 1'b0;
        end
        else
        begin
            prefix_count_reg <= prefix_count_next;
            cut_length_reg   <= cut_length_next;
            suffix_count_reg <= suffix_count_next;
            dot_seen_reg     <= dot_seen_next;
            started_reg      <= started_next;
        end
    end

    // Store contents beyond the counts are never shown, so they need no reset.
    always_ff @(posedge clk)
    begin
        prefix_store_reg <= prefix_store_next;
        suffix_store_reg <= suffix_store_next;
    end

    always_comb
    begin
        logic [3:0] keep;
        logic [7:0] b;
        keep = dot_seen_reg ? cut_length_reg : prefix_count_reg;
        res.status     = !started_reg;
        res.name_bytes = '0;
        res.ext_bytes  = '0;
        for (int i = 0; i < NameLen; i++)
        begin
            b = (started_reg && 4'(i) < keep) ? prefix_store_reg[i] : SPACE_CODE;
            if (i == 0 && b == DELETED_MARK)
            begin
                b = DELETED_ESC;
            end
            res.name_bytes[8*i +: 8] = b;
        end
        for (int i = 0; i < ExtLen; i++)
        begin
            b = (started_reg && dot_seen_reg && 2'(i) < suffix_count_reg)
                ? suffix_store_reg[i] : SPACE_CODE;
            res.ext_bytes[8*i +: 8] = b;
        end
    end

endmodule

// ===== hdl/fts_out_reg.sv =====
// Result register of the short name unit, facing the output stream.
// Depends on fts_pkg.
module fts_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fts_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [87:0]      m_tdata,
    output logic             m_tuser
);
    import fts_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.ext_bytes, res_reg.name_bytes};
    assign m_tuser  = res_reg.status;

endmodule

// ===== hdl/fat_text_to_short_name_unit.sv =====
// Throughput: one byte per cycle, with no gaps between names, except that a terminator
// waits in the input register while the result register is still occupied.
// Each byte passes the input register, then one combinational update of the stores
// and the result register; the result register decouples the output stall.
// Reset (rst_n low, asynchronous) empties both registers and clears the name state.
// Depends on fts_pkg, fts_in_stage, fts_assemble and fts_out_reg.
module fat_text_to_short_name_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,   // end_of_name: the terminator, s_tdata is ignored
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // name_bytes[63:0], ext_bytes[87:64]
    output logic        m_tuser    // status: 1 when the name was empty
);
    import fts_pkg::*;

    logic       st_valid;
    char_info_t st_info;
    logic       go;
    logic       res_load;
    result_t    res;
    logic       out_free;

    // The input register holds one upper-cased, classified byte. It moves on
    // in the next cycle unless it is a terminator and the result register is
    // still occupied, so a stalled output backs up only one transfer deep.
    fts_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ch    (s_tdata),
        .in_last  (s_tlast),
        .go       (go),
        .st_valid (st_valid),
        .st_info  (st_info)
    );

    // The assembler keeps the first eight non-space, non-null bytes, the prefix
    // length at the latest separator dot and the first three such bytes after
    // it. On a terminator it builds the space-padded name and extension,
    // escapes a leading deleted mark and clears its state for the next name.
    fts_assemble u_asm (
        .clk      (clk),
        .rst_n    (rst_n),
        .st_valid (st_valid),
        .st_info  (st_info),
        .out_free (out_free),
        .go       (go),
        .res_load (res_load),
        .res      (res)
    );

    // The result register holds one finished name until it is taken.
    fts_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/fts_checker.sv =====
// Port-level checker for the short name unit and its bind to the top level.
// Depends on fat_text_to_short_name_unit_assert.svh.
module fts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser
);
`include "fat_text_to_short_name_unit_assert.svh"

    // A stalled result keeps its value.
    `FTS_ASSERT(a_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // An empty name yields spaces only.
    `FTS_ASSERT(a_empty, clk, rst_n, m_tvalid && m_tuser |-> m_tdata == {11{8'h20}}, "failed name is not all spaces")

    // A leading deleted mark never leaves the unit unescaped.
    `FTS_ASSERT(a_escape, clk, rst_n, m_tvalid |-> m_tdata[7:0] != 8'hE5, "leading 0xE5 not escaped")

    // A fresh result follows a terminator transfer that has passed the input register and then the result register.
    `FTS_ASSERT(a_cause, clk, rst_n, m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2), "result without terminator")

    // No result is offered while reset is held.
    `FTS_ASSERT_ALWAYS(a_rst, clk, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind fat_text_to_short_name_unit fts_checker u_fts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
